// ----- sv/ita_pkg.sv -----
// shared constants, codes and helpers of the integer to ascii converter
`timescale 1ns / 1ps

package ita_pkg;

  // format codes
  localparam logic [2:0] CMD_UDEC = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_HEX  = 3'd2;
  localparam logic [2:0] CMD_OCT  = 3'd3;
  localparam logic [2:0] CMD_BIN  = 3'd4;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  // binary format width, clamped to what one item may give
  localparam int BIN_BITS  = 16;
  localparam int MAX_CHARS = 16;
  localparam int BIN_W     = (BIN_BITS > MAX_CHARS) ? MAX_CHARS :
                             ((BIN_BITS < 1) ? 1 : BIN_BITS);
  localparam int BCNT_W    = $clog2(BIN_W + 1);

  // digit stack: octal of 32 bits needs the most digits
  localparam int DIGIT_W   = 4;
  localparam int STK_DEPTH = (VALUE_W + 2) / 3;
  localparam int STK_W     = $clog2(STK_DEPTH + 1);

  // divide by ten as multiply by reciprocal and shift
  localparam int                 PROD_W    = 2 * VALUE_W;
  localparam logic [VALUE_W-1:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SH  = 35;
  localparam int                 QUOT_W    = PROD_W - RECIP_SH;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_ONE   = 8'd49;
  localparam logic [CHAR_W-1:0] ASCII_A     = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] DIGIT_TEN   = 8'd10;

  // one digit value to its ascii code, uppercase letters above nine
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (dx > 8'd9) begin
      return dx - DIGIT_TEN + ASCII_A;
    end
    return dx + ASCII_ZERO;
  endfunction

endpackage

// ----- sv/ita_if.sv -----
// valid/ready channel interfaces for number items and character items
`timescale 1ns / 1ps

interface ita_in_if;
  logic                          valid;
  logic                          ready;
  logic [ita_pkg::CMD_W-1:0]     cmd;
  logic [ita_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface ita_out_if;
  logic                          valid;
  logic                          ready;
  logic [ita_pkg::CHAR_W-1:0]    char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- sv/integer_to_ascii_digits.sv -----
// integer to ascii converter: digit sequencer, shared divide unit and digit stack
`timescale 1ns / 1ps

// Usage
//   in_ch takes one item: a 32-bit value and a format code (unsigned decimal,
//   signed decimal, uppercase hex, octal, 16-bit binary). out_ch gives the
//   ascii characters of that number, most significant first, one item per
//   character, with last set on the final one. Unused format codes are
//   taken and give no characters.
//   The block works on one number at a time: in_ch.ready is high only while
//   it is idle. Digits are found least significant first by one shared unit
//   and pushed onto a stack, then popped out. Decimal uses a reciprocal
//   multiply and a subtract, the product registered in S_MUL and the digit
//   pushed in S_DIV; hex and octal use a shift in S_SHIFT. Binary goes out
//   at once, one bit per cycle while out_ch.ready stays high. After the
//   digits come one character per cycle while out_ch.ready stays high.
//   A stall on out_ch simply holds the current character until it is taken.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any number in progress.

module integer_to_ascii_digits (
  input  logic     clk,
  input  logic     rst_n,
  ita_in_if.sink   in_ch,
  ita_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_SIGN  = 7'b0010000,
    S_POP   = 7'b0100000,
    S_BIN   = 7'b1000000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [ita_pkg::VALUE_W-1:0]       mag_r, mag_nxt;
  logic [ita_pkg::PROD_W-1:0]        prod_r;
  logic                              neg_r, neg_nxt;
  logic                              is_hex_r, is_hex_nxt;
  logic [ita_pkg::DIGIT_W-1:0]       stk_r [ita_pkg::STK_DEPTH];
  logic [ita_pkg::STK_W-1:0]         depth_r, depth_nxt;
  logic [ita_pkg::BIN_W-1:0]         bin_r, bin_nxt;
  logic [ita_pkg::BCNT_W-1:0]        bcnt_r, bcnt_nxt;

  logic                              in_acc, out_acc;
  logic                              push, pop;
  logic [ita_pkg::DIGIT_W-1:0]       push_digit;
  logic [ita_pkg::VALUE_W-1:0]       quot, quot_x10, rem;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // divide step: quotient from the registered product, remainder by shift-add and subtract
  assign quot     = {{(ita_pkg::VALUE_W - ita_pkg::QUOT_W){1'b0}},
                     prod_r[ita_pkg::PROD_W-1:ita_pkg::RECIP_SH]};
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = mag_r - quot_x10;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    is_hex_nxt = is_hex_r;
    depth_nxt  = depth_r;
    bin_nxt    = bin_r;
    bcnt_nxt   = bcnt_r;
    push       = 1'b0;
    pop        = 1'b0;
    push_digit = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt    = 1'b0;
          is_hex_nxt = (in_ch.cmd == ita_pkg::CMD_HEX);
          mag_nxt    = in_ch.value;
          depth_nxt  = '0;
          case (in_ch.cmd)
            ita_pkg::CMD_UDEC: state_nxt = S_MUL;
            ita_pkg::CMD_SDEC: begin
              state_nxt = S_MUL;
              if (in_ch.value[ita_pkg::VALUE_W-1]) begin
                neg_nxt = 1'b1;
                mag_nxt = '0 - in_ch.value;
              end
            end
            ita_pkg::CMD_HEX: state_nxt = S_SHIFT;
            ita_pkg::CMD_OCT: state_nxt = S_SHIFT;
            ita_pkg::CMD_BIN: begin
              state_nxt = S_BIN;
              bin_nxt   = in_ch.value[ita_pkg::BIN_W-1:0];
              bcnt_nxt  = ita_pkg::BCNT_W'(ita_pkg::BIN_W);
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        push       = 1'b1;
        push_digit = rem[ita_pkg::DIGIT_W-1:0];
        depth_nxt  = depth_r + 1'b1;
        mag_nxt    = quot;
        if (quot == '0) begin
          state_nxt = neg_r ? S_SIGN : S_POP;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SHIFT: begin
        push      = 1'b1;
        depth_nxt = depth_r + 1'b1;
        if (is_hex_r) begin
          push_digit = mag_r[3:0];
          mag_nxt    = mag_r >> 4;
        end else begin
          push_digit = {1'b0, mag_r[2:0]};
          mag_nxt    = mag_r >> 3;
        end
        if (mag_nxt == '0) begin
          state_nxt = S_POP;
        end
      end
      S_SIGN: begin
        if (out_acc) begin
          neg_nxt   = 1'b0;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (out_acc) begin
          pop       = 1'b1;
          depth_nxt = depth_r - 1'b1;
          if (depth_r == ita_pkg::STK_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_BIN: begin
        if (out_acc) begin
          bin_nxt  = bin_r << 1;
          bcnt_nxt = bcnt_r - 1'b1;
          if (bcnt_r == ita_pkg::BCNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
      bcnt_r  <= '0;
      neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      bcnt_r  <= bcnt_nxt;
      neg_r   <= neg_nxt;
    end
  end

  // datapath registers: multiplier output registered before the subtract
  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    is_hex_r <= is_hex_nxt;
    bin_r    <= bin_nxt;
    prod_r   <= ita_pkg::PROD_W'(mag_r) * ita_pkg::PROD_W'(ita_pkg::RECIP10);
  end

  // digit stack, top at entry zero
  always_ff @(posedge clk) begin
    if (push) begin
      stk_r[0] <= push_digit;
      for (int i = 1; i < ita_pkg::STK_DEPTH; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < ita_pkg::STK_DEPTH - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
    end
  end

  // channel outputs
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_SIGN) || (state_r == S_POP) || (state_r == S_BIN);

  always_comb begin
    case (state_r)
      S_SIGN: begin
        out_ch.char_code = ita_pkg::ASCII_MINUS;
        out_ch.last      = 1'b0;
      end
      S_BIN: begin
        out_ch.char_code = bin_r[ita_pkg::BIN_W-1] ? ita_pkg::ASCII_ONE : ita_pkg::ASCII_ZERO;
        out_ch.last      = (bcnt_r == ita_pkg::BCNT_W'(1));
      end
      default: begin
        out_ch.char_code = ita_pkg::digit_char(stk_r[0]);
        out_ch.last      = (depth_r == ita_pkg::STK_W'(1));
      end
    endcase
  end

endmodule

// ----- sv/ita_checker.sv -----
// port-level checks of the integer to ascii converter, bound to the top level
`timescale 1ns / 1ps

module ita_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [ita_pkg::CMD_W-1:0]     in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ita_pkg::CHAR_W-1:0]    out_char,
  input logic                          out_last
);

  // never takes a number while characters are pending
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a character is offered");

  // a stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("character changed under stall");

  // binary starts next cycle with a bit character
  a_bin_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == ita_pkg::CMD_BIN |=>
      out_valid && (out_char == ita_pkg::ASCII_ZERO || out_char == ita_pkg::ASCII_ONE))
    else $error("binary item did not start");

  // final character frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after last character");

  // unused format codes give nothing
  a_bad_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd != ita_pkg::CMD_UDEC && in_cmd != ita_pkg::CMD_SDEC &&
      in_cmd != ita_pkg::CMD_HEX && in_cmd != ita_pkg::CMD_OCT &&
      in_cmd != ita_pkg::CMD_BIN |=> in_ready && !out_valid)
    else $error("unused format code produced output");

endmodule

bind integer_to_ascii_digits ita_checker u_ita_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_code),
  .out_last  (out_ch.last)
);
